@@ src/drtm_pkg.sv @@
// ----------------------------------------------------------------------------
// drtm_pkg
// Shared types and constants for the descriptor ratio-test matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package drtm_pkg;

   localparam int MAX_REFS    = 512;
   localparam int DESC_WORDS  = 4;
   localparam int DESC_BYTES  = DESC_WORDS * 8;
   localparam int DESC_BITS   = DESC_WORDS * 64;
   localparam int IDX_W       = $clog2(MAX_REFS);
   localparam int CNT_W       = $clog2(MAX_REFS + 1);
   localparam int SQ_W        = 16;
   localparam int PSUM_W      = 19;
   localparam int DIST_W      = 21;
   localparam int BEST_IDX_W  = 9;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_LOAD  = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] desc_word0;
      logic [63:0] desc_word1;
      logic [63:0] desc_word2;
      logic [63:0] desc_word3;
   } req_type;

   typedef struct packed {
      logic                  match_found;
      logic [BEST_IDX_W-1:0] best_index;
      logic [DIST_W-1:0]     best_sq_dist;
      logic [DIST_W-1:0]     second_sq_dist;
      logic                  best_present;
      logic                  second_present;
   } rsp_type;

   typedef struct packed {
      op_type               op;
      logic [DESC_BITS-1:0] desc;
   } cmd_type;

endpackage

`default_nettype wire

@@ src/descriptor_ratio_test_matcher.sv @@
// ----------------------------------------------------------------------------
// descriptor_ratio_test_matcher
// Brute-force nearest-neighbor descriptor matcher with a ratio test.
// ----------------------------------------------------------------------------
// Request transactions carry an action and a 256-bit descriptor. A clear
// empties the reference store, a load appends one descriptor (ignored when
// the store is full), and a query produces exactly one response transaction
// with the nearest reference, the two smallest squared distances and the
// ratio-test verdict. Clears, loads and unused action codes give no response.
// A front register and a four-entry command queue decouple the request side
// from the matching engine, so requests keep being taken while a query scans,
// as long as the queue has room. Clears and loads complete in the engine's
// idle state. A query with N stored references reads one reference per cycle
// from the reference memory and runs each through a four-stage distance
// pipeline; its response is then registered in the output register, and the
// engine is ready for its next command once the response is valid. An empty
// store skips the scan and answers from the finish state. Commands pass
// through the front register and the queue before the engine takes them.
// Reset empties the store and the queue; the store contents are not cleared,
// only the reference count. When the response receiver stalls, the finished
// result is held in the output register and the engine waits before it
// completes the next query, while clears and loads continue to run.
// ----------------------------------------------------------------------------
`default_nettype none

module descriptor_ratio_test_matcher (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire drtm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output drtm_pkg::rsp_type      rsp_data
);
   import drtm_pkg::*;

   logic    f_valid, f_ready;
   cmd_type f_data;
   logic    q_valid, q_ready;
   cmd_type q_data;

   drtm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (f_valid),
      .cmd_ready (f_ready),
      .cmd_data  (f_data)
   );

   drtm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   drtm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd_data  (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ src/drtm_front.sv @@
// ----------------------------------------------------------------------------
// drtm_front
// Accepts request transactions, decodes the action and registers a command
// for the queue. Unused action codes are dropped here.
// ----------------------------------------------------------------------------
`default_nettype none

module drtm_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire drtm_pkg::req_type req_data,
   output logic                   cmd_valid,
   input  wire logic              cmd_ready,
   output drtm_pkg::cmd_type      cmd_data
);
   import drtm_pkg::*;

   logic        cmd_valid_ff, cmd_valid_in;
   cmd_type     cmd_ff, cmd_in;
   logic        keep;
   logic        accept;
   logic [63:0] words [4];

   assign req_ready = !cmd_valid_ff || cmd_ready;
   assign accept    = req_valid && req_ready;
   assign cmd_valid = cmd_valid_ff;
   assign cmd_data  = cmd_ff;

   assign words[0] = req_data.desc_word0;
   assign words[1] = req_data.desc_word1;
   assign words[2] = req_data.desc_word2;
   assign words[3] = req_data.desc_word3;

   always_comb begin
      keep      = 1'b1;
      cmd_in.op = OP_CLEAR;
      for (int w = 0; w < DESC_WORDS; w++) begin
         cmd_in.desc[64*w +: 64] = words[w];
      end
      unique case (req_data.action)
         ACT_CLEAR: cmd_in.op = OP_CLEAR;
         ACT_LOAD:  cmd_in.op = OP_LOAD;
         ACT_QUERY: cmd_in.op = OP_QUERY;
         default:   keep = 1'b0;
      endcase
   end

   always_comb begin
      cmd_valid_in = cmd_valid_ff;
      if (accept) begin
         cmd_valid_in = keep;
      end else if (cmd_ready) begin
         cmd_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

`default_nettype wire

@@ src/drtm_queue.sv @@
// ----------------------------------------------------------------------------
// drtm_queue
// Short command FIFO between the front end and the matching engine.
// ----------------------------------------------------------------------------
`default_nettype none

module drtm_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire drtm_pkg::cmd_type push_data,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output drtm_pkg::cmd_type      pop_data
);
   import drtm_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   logic              push, pop;

   assign push_ready = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill count exceeds depth");
`endif

endmodule

`default_nettype wire

@@ src/drtm_back.sv @@
// ----------------------------------------------------------------------------
// drtm_back
// Matching engine: holds the reference store, executes clear and load
// commands, and scans the store for queries through a distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module drtm_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire drtm_pkg::cmd_type cmd_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output drtm_pkg::rsp_type      rsp_data
);
   import drtm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic                 issuing_ff, issuing_in;
   logic [DESC_BITS-1:0] query_ff;

   logic [DESC_BITS-1:0] ref_mem [MAX_REFS];
   logic                 mem_we;
   logic                 rd_en;
   logic [DESC_BITS-1:0] rd_data_ff;

   // Distance pipeline: read, square, per-word sum, total.
   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic [IDX_W-1:0]     idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic [SQ_W-1:0]      sq_ff [DESC_BYTES];
   logic [SQ_W-1:0]      sq_in [DESC_BYTES];
   logic [PSUM_W-1:0]    psum_ff [DESC_WORDS];
   logic [PSUM_W-1:0]    psum_in [DESC_WORDS];
   logic [DIST_W-1:0]    dist_ff, dist_in;

   logic [DIST_W-1:0]    best_ff, best_in;
   logic [DIST_W-1:0]    second_ff, second_in;
   logic [IDX_W-1:0]     bidx_ff, bidx_in;
   logic                 have_best_ff, have_best_in;
   logic                 have_second_ff, have_second_in;

   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff, out_in;
   logic                 out_free;
   logic                 pipe_empty;
   logic [DIST_W+4:0]    best_x25;
   logic [DIST_W+4:0]    second_x16;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign pipe_empty = !issuing_ff && !v1_ff && !v2_ff && !v3_ff && !v4_ff;
   assign cmd_ready  = (state_ff == ST_IDLE);
   assign rd_en      = (state_ff == ST_SCAN) && issuing_ff;
   assign mem_we     = (state_ff == ST_IDLE) && cmd_valid && (cmd_data.op == OP_LOAD)
                       && (count_ff < CNT_W'(MAX_REFS));
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_ff;

   always_comb begin
      logic [7:0] qa, rb, d;
      for (int b = 0; b < DESC_BYTES; b++) begin
         qa       = query_ff[8*b +: 8];
         rb       = rd_data_ff[8*b +: 8];
         d        = (qa > rb) ? qa - rb : rb - qa;
         sq_in[b] = SQ_W'(d) * SQ_W'(d);
      end
   end

   always_comb begin
      for (int w = 0; w < DESC_WORDS; w++) begin
         psum_in[w] = '0;
         for (int k = 0; k < 8; k++) begin
            psum_in[w] = psum_in[w] + PSUM_W'(sq_ff[8*w + k]);
         end
      end
      dist_in = '0;
      for (int w = 0; w < DESC_WORDS; w++) begin
         dist_in = dist_in + DIST_W'(psum_ff[w]);
      end
   end

   // The ratio test 25*best < 16*second, written as shifts and adds.
   assign best_x25   = ((DIST_W+5)'(best_ff) << 4) + ((DIST_W+5)'(best_ff) << 3)
                       + (DIST_W+5)'(best_ff);
   assign second_x16 = (DIST_W+5)'(second_ff) << 4;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      scan_in        = scan_ff;
      issuing_in     = issuing_ff;
      best_in        = best_ff;
      second_in      = second_ff;
      bidx_in        = bidx_ff;
      have_best_in   = have_best_ff;
      have_second_in = have_second_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_in         = out_ff;

      if (v4_ff) begin
         if (!have_best_ff || dist_ff < best_ff) begin
            if (have_best_ff) begin
               second_in      = best_ff;
               have_second_in = 1'b1;
            end
            best_in      = dist_ff;
            bidx_in      = idx4_ff;
            have_best_in = 1'b1;
         end else if (!have_second_ff || dist_ff < second_ff) begin
            second_in      = dist_ff;
            have_second_in = 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_data.op)
                  OP_CLEAR: count_in = '0;
                  OP_LOAD: begin
                     if (count_ff < CNT_W'(MAX_REFS)) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     scan_in        = '0;
                     best_in        = '0;
                     second_in      = '0;
                     bidx_in        = '0;
                     have_best_in   = 1'b0;
                     have_second_in = 1'b0;
                     issuing_in     = (count_ff != '0);
                     state_in       = (count_ff != '0) ? ST_SCAN : ST_FINISH;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (issuing_ff) begin
               scan_in = scan_ff + 1'b1;
               if (scan_ff + 1'b1 == count_ff) begin
                  issuing_in = 1'b0;
               end
            end else if (pipe_empty) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_valid_in          = 1'b1;
               out_in.match_found    = have_best_ff && (!have_second_ff
                                       || (best_x25 < second_x16));
               out_in.best_index     = BEST_IDX_W'(bidx_ff);
               out_in.best_sq_dist   = best_ff;
               out_in.second_sq_dist = second_ff;
               out_in.best_present   = have_best_ff;
               out_in.second_present = have_second_ff;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issuing_ff   <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issuing_ff   <= issuing_in;
         v1_ff        <= rd_en;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         out_valid_ff <= out_valid_in;
      end
      scan_ff        <= scan_in;
      best_ff        <= best_in;
      second_ff      <= second_in;
      bidx_ff        <= bidx_in;
      have_best_ff   <= have_best_in;
      have_second_ff <= have_second_in;
      out_ff         <= out_in;
      idx1_ff        <= scan_ff[IDX_W-1:0];
      idx2_ff        <= idx1_ff;
      idx3_ff        <= idx2_ff;
      idx4_ff        <= idx3_ff;
      sq_ff          <= sq_in;
      psum_ff        <= psum_in;
      dist_ff        <= dist_in;
      if ((state_ff == ST_IDLE) && cmd_valid && (cmd_data.op == OP_QUERY)) begin
         query_ff <= cmd_data.desc;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ref_mem[count_ff[IDX_W-1:0]] <= cmd_data.desc;
      end
      if (rd_en) begin
         rd_data_ff <= ref_mem[scan_ff[IDX_W-1:0]];
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_REFS))
      else $error("reference count exceeds store size");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> (CNT_W'(idx4_ff) < count_ff))
      else $error("distance result for a slot beyond the stored count");

   a_second_needs_best: assert property (@(posedge clock) disable iff (reset)
      have_second_ff |-> have_best_ff)
      else $error("second nearest recorded without a nearest");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && out_free |=> out_valid_ff)
      else $error("query finished without a response");
`endif

endmodule

`default_nettype wire
